FILE: hdl/ldtw_pkg.sv
package ldtw_pkg;

  localparam int unsigned BRIGHT_W = 3;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PC_W     = 4;
  localparam int unsigned BIT_IDX_W = 3;

  localparam logic [BYTE_W-1:0] CMD_AUTO_INC = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_FIXED    = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_ADDRESS  = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY  = 8'h88;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_STOP  = 2'd2
  } sym_t;

  typedef enum logic [1:0] {
    SRC_CMD  = 2'd0,
    SRC_ADDR = 2'd1,
    SRC_DATA = 2'd2,
    SRC_DISP = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    END_NONE    = 2'd0,
    END_IF_OPEN = 2'd1,
    END_ALWAYS  = 2'd2
  } end_t;

  typedef struct packed {
    sym_t sym;
    src_t src;
    end_t fin;
  } ucode_t;

  // program entry points
  localparam logic [PC_W-1:0] PC_HEADER = 4'd0;
  localparam logic [PC_W-1:0] PC_DATA   = 4'd5;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t cw;
    case (pc)
      4'd0:    cw = '{sym: SYM_START, src: SRC_CMD,  fin: END_NONE};
      4'd1:    cw = '{sym: SYM_BIT,   src: SRC_CMD,  fin: END_NONE};
      4'd2:    cw = '{sym: SYM_STOP,  src: SRC_CMD,  fin: END_NONE};
      4'd3:    cw = '{sym: SYM_START, src: SRC_ADDR, fin: END_NONE};
      4'd4:    cw = '{sym: SYM_BIT,   src: SRC_ADDR, fin: END_NONE};
      4'd5:    cw = '{sym: SYM_BIT,   src: SRC_DATA, fin: END_IF_OPEN};
      4'd6:    cw = '{sym: SYM_STOP,  src: SRC_DISP, fin: END_NONE};
      4'd7:    cw = '{sym: SYM_START, src: SRC_DISP, fin: END_NONE};
      4'd8:    cw = '{sym: SYM_BIT,   src: SRC_DISP, fin: END_NONE};
      4'd9:    cw = '{sym: SYM_STOP,  src: SRC_DISP, fin: END_ALWAYS};
      default: cw = '{sym: SYM_STOP,  src: SRC_DISP, fin: END_ALWAYS};
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/ldtw_if.sv
interface ldtw_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] address;
  logic [7:0] data_byte;
  logic       first_element;
  logic       last_element;

  modport source (output valid, operation, address, data_byte, first_element, last_element,
                  input ready);
  modport sink (input valid, operation, address, data_byte, first_element, last_element,
                output ready);
endinterface

interface ldtw_sym_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       bit_value;
  logic       last_of_run;

  modport source (output valid, symbol, bit_value, last_of_run, input ready);
  modport sink (input valid, symbol, bit_value, last_of_run, output ready);
endinterface

FILE: hdl/led_driver_two_wire_write_framer.sv
// the first symbol is offered in the cycle after an item is accepted
// throughput: one symbol per cycle while symbols.ready is high; an item causes
// 8 to 38 symbols (a single write 38), set by the one-symbol-per-step sequencer
// the next item is accepted in the cycle its final symbol is taken
// reset (rst, synchronous): sequencer idle, no sequence open, brightness 0
module led_driver_two_wire_write_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_data,
  ldtw_item_if.sink           items,
  ldtw_sym_if.source          symbols
);

  logic                                 busy;
  logic [ldtw_pkg::PC_W-1:0]            pc;
  logic [ldtw_pkg::BIT_IDX_W-1:0]       bit_idx;
  logic                                 op_q;
  logic [ldtw_pkg::ADDR_W-1:0]          addr_q;
  logic [ldtw_pkg::BYTE_W-1:0]          data_q;
  logic                                 last_q;
  logic                                 seq_open;
  logic [ldtw_pkg::BRIGHT_W-1:0]        brightness;

  ldtw_pkg::ucode_t                     cw;
  logic [ldtw_pkg::BYTE_W-1:0]          byte_val;
  logic                                 step_done;
  logic                                 run_end;
  logic                                 fire;
  logic                                 accept;
  logic [ldtw_pkg::PC_W-1:0]            entry;

  assign cw = ldtw_pkg::ucode(pc);

  always_comb begin
    case (cw.src)
      ldtw_pkg::SRC_CMD:  byte_val = op_q ? ldtw_pkg::CMD_AUTO_INC : ldtw_pkg::CMD_FIXED;
      ldtw_pkg::SRC_ADDR: byte_val = ldtw_pkg::CMD_ADDRESS | {4'b0, addr_q};
      ldtw_pkg::SRC_DATA: byte_val = data_q;
      ldtw_pkg::SRC_DISP: byte_val = ldtw_pkg::CMD_DISPLAY + {5'b0, brightness};
      default:            byte_val = data_q;
    endcase
  end

  assign step_done = (cw.sym != ldtw_pkg::SYM_BIT) || (bit_idx == 3'd7);
  // a sequence element without a last mark stops after its data byte
  assign run_end = step_done && ((cw.fin == ldtw_pkg::END_ALWAYS) ||
                   ((cw.fin == ldtw_pkg::END_IF_OPEN) && op_q && !last_q));

  assign symbols.valid       = busy;
  assign symbols.symbol      = cw.sym;
  assign symbols.bit_value   = (cw.sym == ldtw_pkg::SYM_BIT) ? byte_val[bit_idx] : 1'b0;
  assign symbols.last_of_run = run_end;

  assign fire        = busy && symbols.ready;
  assign items.ready = !busy || (fire && run_end);
  assign accept      = items.valid && items.ready;

  // header is skipped only for a continuing sequence element
  assign entry = (items.operation && !items.first_element && seq_open) ?
                 ldtw_pkg::PC_DATA : ldtw_pkg::PC_HEADER;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      seq_open   <= 1'b0;
      brightness <= '0;
      pc         <= ldtw_pkg::PC_HEADER;
      bit_idx    <= '0;
    end else begin
      if (cfg_write) begin
        brightness <= cfg_data;
      end
      if (accept) begin
        busy     <= 1'b1;
        pc       <= entry;
        bit_idx  <= '0;
        seq_open <= items.operation && !items.last_element;
      end else if (fire) begin
        if (run_end) begin
          busy <= 1'b0;
        end else if (step_done) begin
          pc      <= pc + 4'd1;
          bit_idx <= '0;
        end else begin
          bit_idx <= bit_idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= items.operation;
      addr_q <= items.address;
      data_q <= items.data_byte;
      last_q <= items.last_element;
    end
  end

endmodule

FILE: tb/sv/led_driver_two_wire_write_framer_test.sv
module led_driver_two_wire_write_framer_test;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    ldtw_pkg::sym_t symbol;
    logic           bit_value;
    logic           last_of_run;
  } line_sym_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_data;

  ldtw_item_if item_bus ();
  ldtw_sym_if  sym_bus ();

  led_driver_two_wire_write_framer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .items     (item_bus),
    .symbols   (sym_bus)
  );

  line_sym_t  expected_line_symbols[$];
  logic       frame_open = 1'b0;
  logic [2:0] brightness_level = 3'd0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL led_driver_two_wire_write_framer");
      $finish;
    end
  end

  function automatic void push_symbol(ldtw_pkg::sym_t s, logic b);
    expected_line_symbols.push_back('{symbol: s, bit_value: b, last_of_run: 1'b0});
  endfunction

  // lsb first on the wire
  function automatic void push_byte(logic [7:0] v);
    for (int i = 0; i < 8; i++) push_symbol(ldtw_pkg::SYM_BIT, v[i]);
  endfunction

  function automatic void push_frame(logic [7:0] v);
    push_symbol(ldtw_pkg::SYM_START, 1'b0);
    push_byte(v);
    push_symbol(ldtw_pkg::SYM_STOP, 1'b0);
  endfunction

  function automatic void predict_line_symbols(logic op, logic [3:0] addr, logic [7:0] data,
                                               logic first, logic last);
    line_sym_t  tail;
    logic [7:0] display_cmd;
    display_cmd = ldtw_pkg::CMD_DISPLAY + {5'd0, brightness_level};
    if (!op) begin
      // an open sequence is dropped without a stop
      push_frame(ldtw_pkg::CMD_FIXED);
      push_symbol(ldtw_pkg::SYM_START, 1'b0);
      push_byte(ldtw_pkg::CMD_ADDRESS + {4'd0, addr});
      push_byte(data);
      push_symbol(ldtw_pkg::SYM_STOP, 1'b0);
      push_frame(display_cmd);
      frame_open = 1'b0;
    end else begin
      if (first || !frame_open) begin
        push_frame(ldtw_pkg::CMD_AUTO_INC);
        push_symbol(ldtw_pkg::SYM_START, 1'b0);
        push_byte(ldtw_pkg::CMD_ADDRESS + {4'd0, addr});
        frame_open = 1'b1;
      end
      push_byte(data);
      if (last) begin
        push_symbol(ldtw_pkg::SYM_STOP, 1'b0);
        push_frame(display_cmd);
        frame_open = 1'b0;
      end
    end
    tail = expected_line_symbols.pop_back();
    tail.last_of_run = 1'b1;
    expected_line_symbols.push_back(tail);
  endfunction

  // compare each taken symbol, then pick the next ready value
  always @(posedge clk) begin
    line_sym_t exp_sym;
    if (!rst && sym_bus.valid && sym_bus.ready) begin
      if (expected_line_symbols.size() == 0) begin
        $error("unexpected symbol %0d bit %0b last %0b",
               sym_bus.symbol, sym_bus.bit_value, sym_bus.last_of_run);
        mismatches++;
      end else begin
        exp_sym = expected_line_symbols.pop_front();
        if (sym_bus.symbol !== exp_sym.symbol) begin
          $error("symbol: expected %0d, got %0d", exp_sym.symbol, sym_bus.symbol);
          mismatches++;
        end
        if (sym_bus.bit_value !== exp_sym.bit_value) begin
          $error("bit_value: expected %0b, got %0b", exp_sym.bit_value, sym_bus.bit_value);
          mismatches++;
        end
        if (sym_bus.last_of_run !== exp_sym.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", exp_sym.last_of_run,
                 sym_bus.last_of_run);
          mismatches++;
        end
      end
    end
    sym_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid is left high after an accepted item so back-to-back items need no toggle
  task automatic send_item(logic op, logic [3:0] addr, logic [7:0] data,
                           logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.operation     <= op;
    item_bus.address       <= addr;
    item_bus.data_byte     <= data;
    item_bus.first_element <= first;
    item_bus.last_element  <= last;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    predict_line_symbols(op, addr, data, first, last);
  endtask

  task automatic wait_until_drained();
    item_bus.valid <= 1'b0;
    while (expected_line_symbols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_brightness(logic [2:0] level);
    wait_until_drained();
    cfg_write <= 1'b1;
    cfg_data  <= level;
    @(posedge clk);
    cfg_write <= 1'b0;
    brightness_level = level;
  endtask

  task automatic test_single_writes();
    send_item(1'b0, 4'd0,  8'h00, 1'b0, 1'b0);
    send_item(1'b0, 4'd15, 8'hFF, 1'b1, 1'b1);
    send_item(1'b0, 4'd9,  8'hA5, 1'b1, 1'b0);
    set_brightness(3'd7);
    send_item(1'b0, 4'd3,  8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_sequences();
    // one element that is both first and last
    send_item(1'b1, 4'd15, 8'hFF, 1'b1, 1'b1);
    // address of a middle element is ignored
    send_item(1'b1, 4'd2,  8'h01, 1'b1, 1'b0);
    send_item(1'b1, 4'd7,  8'h80, 1'b0, 1'b0);
    send_item(1'b1, 4'd0,  8'h3C, 1'b0, 1'b1);
    // no first mark and nothing open: header goes out anyway
    send_item(1'b1, 4'd5,  8'h11, 1'b0, 1'b0);
    send_item(1'b1, 4'd6,  8'h22, 1'b0, 1'b1);
    // restart while open
    send_item(1'b1, 4'd1,  8'h33, 1'b1, 1'b0);
    send_item(1'b1, 4'd4,  8'h44, 1'b1, 1'b1);
    // single write cuts an open sequence
    send_item(1'b1, 4'd8,  8'h55, 1'b1, 1'b0);
    send_item(1'b0, 4'd12, 8'h66, 1'b0, 1'b0);
    send_item(1'b1, 4'd3,  8'h77, 1'b0, 1'b1);
  endtask

  task automatic test_brightness_while_open();
    set_brightness(3'd5);
    send_item(1'b1, 4'd10, 8'hC3, 1'b1, 1'b0);
    set_brightness(3'd2);
    send_item(1'b1, 4'd11, 8'h3C, 1'b0, 1'b1);
    set_brightness(3'd0);
    send_item(1'b1, 4'd14, 8'h0F, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int item_total);
    int sent;
    int kind;
    int len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < item_total) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_item(1'b0, 4'($urandom_range(15)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (kind < 85) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          send_item(1'b1, 4'($urandom_range(15)), 8'($urandom_range(255)),
                    i == 0, i == len - 1);
          sent++;
        end
      end else begin
        // broken sequences and stray marks
        send_item(1'($urandom_range(1)), 4'($urandom_range(15)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= 3'd0;
    item_bus.valid         <= 1'b0;
    item_bus.operation     <= 1'b0;
    item_bus.address       <= 4'd0;
    item_bus.data_byte     <= 8'd0;
    item_bus.first_element <= 1'b0;
    item_bus.last_element  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 45;
    test_single_writes();
    test_sequences();
    test_brightness_while_open();

    set_brightness(3'($urandom_range(7)));
    test_random_traffic(23, 45, 145);
    set_brightness(3'd7);
    test_random_traffic(45, 23, 145);
    set_brightness(3'($urandom_range(7)));
    test_random_traffic(0, 0, 145);

    wait_until_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS led_driver_two_wire_write_framer");
    end else begin
      $display("FAIL led_driver_two_wire_write_framer");
    end
    $finish;
  end

endmodule
